FILE: sv/q16mds_pkg.sv
// shared types, codes and helpers of the q16.16 mul/div/sqrt unit
package q16mds_pkg;

	typedef enum logic [1:0] {
		OP_MUL  = 2'd0,
		OP_DIV  = 2'd1,
		OP_SQRT = 2'd2
	} op_t;

	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_OVF  = 2'd1,
		ST_DIVZ = 2'd2
	} status_t;

	localparam logic [31:0] MIN_WORD = 32'h8000_0000;
	localparam int unsigned NUM_STEPS = 32;
	localparam int unsigned SQRT_STEPS = 24;

	typedef struct packed {
		op_t         kind;
		logic        rnd;
		logic        neg;
		status_t     stat;
		logic [31:0] opa;
		logic [31:0] opb;
		logic [32:0] rem;
		logic [31:0] quot;
		logic [63:0] prod;
	} stage_t;

	function automatic logic [31:0] abs32(input logic [31:0] x);
		abs32 = x[31] ? (32'd0 - x) : x;
	endfunction

endpackage

FILE: sv/q16mds_if.sv
// valid/ready channels for operation requests and results
interface q16mds_in_if;
	logic               valid;
	logic               ready;
	logic [1:0]         kind;
	logic signed [31:0] operand_a;
	logic signed [31:0] operand_b;

	modport source(output valid, kind, operand_a, operand_b, input ready);
	modport sink(input valid, kind, operand_a, operand_b, output ready);
endinterface

interface q16mds_out_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] value;
	logic [1:0]         status;

	modport source(output valid, value, status, input ready);
	modport sink(input valid, value, status, output ready);
endinterface

FILE: sv/q16mds_step.sv
// one pipeline stage: a divide quotient bit, a square root digit or a multiply step
module q16mds_step #(
	parameter int unsigned IDX = 0
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                adv,
	input  logic                in_vld,
	input  q16mds_pkg::stage_t  in_stage,
	output logic                out_vld,
	output q16mds_pkg::stage_t  out_stage
);

	localparam int unsigned DIV_K = q16mds_pkg::NUM_STEPS - 1 - IDX;
	localparam bit DO_SQRT = (IDX < q16mds_pkg::SQRT_STEPS);
	localparam int unsigned SQ_J = DO_SQRT ? (q16mds_pkg::SQRT_STEPS - 1 - IDX) : 0;

	q16mds_pkg::stage_t nx;
	logic vld_s;
	q16mds_pkg::stage_t stage_s;

	always_comb begin
		logic signed [63:0] p;
		logic               top_ovf;
		logic [32:0]        r33;
		logic [48:0]        num;
		logic [32:0]        dtrial;
		logic [47:0]        rad;
		logic [27:0]        spre;
		logic [27:0]        strial;
		nx = in_stage;
		p = '0;
		top_ovf = 1'b0;
		r33 = '0;
		num = {in_stage.opa, 17'd0};
		dtrial = {in_stage.rem[31:0], num[DIV_K]};
		rad = {in_stage.opa, 16'd0};
		spre = {in_stage.rem[25:0], rad[2*SQ_J +: 2]};
		strial = {2'b00, in_stage.quot[23:0], 2'b01};
		case (in_stage.kind)
			q16mds_pkg::OP_MUL: begin
				if (IDX == 0) begin
					p = $signed(in_stage.opa) * $signed(in_stage.opb);
					nx.prod = p;
				end else if (IDX == 1) begin
					// overflow is judged on the exact product, before the bias
					top_ovf = !((&in_stage.prod[63:47]) || !(|in_stage.prod[63:47]));
					nx.prod = in_stage.prod - {63'd0, in_stage.rnd & in_stage.prod[63]};
					nx.stat = top_ovf ? q16mds_pkg::ST_OVF : q16mds_pkg::ST_OK;
				end else if (IDX == 2) begin
					// the bias can carry below bit 47, so the sign comes from bit 63
					r33 = {in_stage.prod[63], in_stage.prod[47:16]}
						+ {32'd0, in_stage.rnd & in_stage.prod[15]};
					if (r33[32] != r33[31])
						nx.stat = q16mds_pkg::ST_OVF;
					nx.quot = r33[31:0];
				end
			end
			q16mds_pkg::OP_DIV: begin
				if (dtrial >= {1'b0, in_stage.opb}) begin
					nx.rem = dtrial - {1'b0, in_stage.opb};
					nx.quot = {in_stage.quot[30:0], 1'b1};
				end else begin
					nx.rem = dtrial;
					nx.quot = {in_stage.quot[30:0], 1'b0};
				end
			end
			q16mds_pkg::OP_SQRT: begin
				if (DO_SQRT) begin
					if (spre >= strial) begin
						nx.rem = {5'd0, spre - strial};
						nx.quot = {in_stage.quot[30:0], 1'b1};
					end else begin
						nx.rem = {5'd0, spre};
						nx.quot = {in_stage.quot[30:0], 1'b0};
					end
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= 1'b0;
		end else if (adv) begin
			vld_s <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			stage_s <= nx;
		end
	end

	assign out_vld = vld_s;
	assign out_stage = stage_s;

endmodule

FILE: sv/q16mds_final.sv
// last stage: rounding, sign and error codes into the output register
module q16mds_final (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                adv,
	input  logic                in_vld,
	input  q16mds_pkg::stage_t  in_stage,
	output logic                out_vld,
	output logic [31:0]         value,
	output logic [1:0]          status
);

	logic        vld_s34;
	logic [31:0] value_s34;
	logic [1:0]  status_s34;
	logic [31:0] val;
	q16mds_pkg::status_t st;

	always_comb begin
		logic [31:0] h;
		logic        c;
		val = 32'd0;
		st = q16mds_pkg::ST_OK;
		h = 32'd0;
		c = 1'b0;
		case (in_stage.kind)
			q16mds_pkg::OP_MUL: begin
				if (in_stage.stat != q16mds_pkg::ST_OK) begin
					val = q16mds_pkg::MIN_WORD;
					st = q16mds_pkg::ST_OVF;
				end else begin
					val = in_stage.quot;
				end
			end
			q16mds_pkg::OP_DIV: begin
				if (in_stage.stat == q16mds_pkg::ST_DIVZ) begin
					val = q16mds_pkg::MIN_WORD;
					st = q16mds_pkg::ST_DIVZ;
				end else if (in_stage.stat == q16mds_pkg::ST_OVF
						|| (in_stage.rnd && (&in_stage.quot))) begin
					val = q16mds_pkg::MIN_WORD;
					st = q16mds_pkg::ST_OVF;
				end else begin
					h = {1'b0, in_stage.quot[31:1]};
					c = in_stage.rnd & in_stage.quot[0];
					// -(h + c) folded into ~h + !c
					val = in_stage.neg ? (~h + {31'd0, !c}) : (h + {31'd0, c});
				end
			end
			q16mds_pkg::OP_SQRT: begin
				h = {8'd0, in_stage.quot[23:0]};
				c = in_stage.rnd && (in_stage.rem[25:0] > {2'b00, in_stage.quot[23:0]});
				val = in_stage.neg ? (~h + {31'd0, !c}) : (h + {31'd0, c});
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s34 <= 1'b0;
		end else if (adv) begin
			vld_s34 <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			value_s34 <= val;
			status_s34 <= st;
		end
	end

	assign out_vld = vld_s34;
	assign value = value_s34;
	assign status = status_s34;

endmodule

FILE: sv/q16_mul_div_sqrt_unit_top.sv
// q16.16 multiply / divide / square root unit, fully pipelined
// the pipeline is an entry register, 32 step stages and an output register;
// each step stage takes a divide quotient bit, a square root bit or a multiply step
// throughput: one transaction per cycle; the whole pipe holds while a result waits
// reset: valid bits cleared, round_q set to 1
module q16_mul_div_sqrt_unit_top (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_wr_en,
	input  logic                 cfg_wr_data,
	q16mds_in_if.sink            req,
	q16mds_out_if.source         rsp
);

	logic round_q;
	logic adv;
	logic vld [0:q16mds_pkg::NUM_STEPS];
	q16mds_pkg::stage_t pipe [0:q16mds_pkg::NUM_STEPS];
	q16mds_pkg::stage_t entry;
	logic vld_s0;
	q16mds_pkg::stage_t stage_s0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			round_q <= 1'b1;
		end else if (cfg_wr_en) begin
			round_q <= cfg_wr_data;
		end
	end

	assign adv = !rsp.valid || rsp.ready;
	assign req.ready = adv;

	always_comb begin
		logic [31:0] na;
		logic [31:0] nb;
		na = q16mds_pkg::abs32(req.operand_a);
		nb = q16mds_pkg::abs32(req.operand_b);
		entry = '0;
		entry.kind = q16mds_pkg::op_t'(req.kind);
		entry.rnd = round_q;
		entry.stat = q16mds_pkg::ST_OK;
		case (q16mds_pkg::op_t'(req.kind))
			q16mds_pkg::OP_MUL: begin
				entry.opa = req.operand_a;
				entry.opb = req.operand_b;
			end
			q16mds_pkg::OP_DIV: begin
				entry.opa = na;
				entry.opb = nb;
				entry.neg = req.operand_a[31] ^ req.operand_b[31];
				// quotient needs more than 32 bits when |a| >= |b| * 2^15
				if (req.operand_b == 32'sd0)
					entry.stat = q16mds_pkg::ST_DIVZ;
				else if ({15'd0, na} >= {nb, 15'd0})
					entry.stat = q16mds_pkg::ST_OVF;
				entry.rem = {16'd0, na[31:15]};
			end
			q16mds_pkg::OP_SQRT: begin
				entry.opa = na;
				entry.neg = req.operand_a[31];
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s0 <= 1'b0;
		end else if (adv) begin
			vld_s0 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			stage_s0 <= entry;
		end
	end

	assign vld[0] = vld_s0;
	assign pipe[0] = stage_s0;

	for (genvar i = 0; i < q16mds_pkg::NUM_STEPS; i++) begin : g_step
		q16mds_step #(
			.IDX(i)
		) u_step (
			.clk       (clk),
			.arst_n    (arst_n),
			.adv       (adv),
			.in_vld    (vld[i]),
			.in_stage  (pipe[i]),
			.out_vld   (vld[i+1]),
			.out_stage (pipe[i+1])
		);
	end

	q16mds_final u_final (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.in_vld   (vld[q16mds_pkg::NUM_STEPS]),
		.in_stage (pipe[q16mds_pkg::NUM_STEPS]),
		.out_vld  (rsp.valid),
		.value    (rsp.value),
		.status   (rsp.status)
	);

`ifndef SYNTHESIS
	a_err_word: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && (rsp.status != q16mds_pkg::ST_OK) |-> rsp.value == q16mds_pkg::MIN_WORD)
		else $error("error status without minimum word");

	a_entry_moves: assert property (@(posedge clk) disable iff (!arst_n)
		adv && vld[0] |=> vld[1])
		else $error("transaction lost between entry and first step");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!adv && vld[5] |=> vld[5] && $stable(pipe[5]))
		else $error("stage changed during stall");
`endif

endmodule

FILE: tb/tb_q16_mul_div_sqrt_unit_top.sv
// testbench of the q16.16 multiply / divide / square root unit
module tb_q16_mul_div_sqrt_unit_top;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		logic [31:0] value;
		logic [1:0]  status;
	} q16_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_wr_en = 1'b0;
	logic cfg_wr_data = 1'b0;

	q16mds_in_if  req();
	q16mds_out_if rsp();

	q16_mul_div_sqrt_unit_top DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.req(req.sink),
		.rsp(rsp.source)
	);

	always #5 clk = ~clk;

	logic        round_on = 1'b1;
	q16_result_t expected_results[$];
	int          mismatch_count = 0;
	int          result_count = 0;
	int          sent_count = 0;
	bit          idle_enable = 1'b1;
	bit          long_hold = 1'b0;

	// predictor
	function automatic q16_result_t q16_compute(logic [1:0] kind, logic [31:0] a,
			logic [31:0] b);
		q16_result_t res;
		logic signed [63:0] prod;
		logic [63:0] up, shv, rv, q, na, nb, n, rem, root, bitv, mag;
		res.value = 32'd0;
		res.status = q16mds_pkg::ST_OK;
		case (kind)
			q16mds_pkg::OP_MUL: begin
				prod = $signed(a) * $signed(b);
				up = prod;
				if (up[63:47] != 17'd0 && up[63:47] != 17'h1FFFF) begin
					res.value = q16mds_pkg::MIN_WORD;
					res.status = q16mds_pkg::ST_OVF;
				end else begin
					if (round_on && prod < 0)
						up = up - 64'd1;
					shv = $signed(up) >>> 16;
					rv = shv;
					if (round_on)
						rv = rv + up[15];
					if (((rv + 64'h8000_0000) >> 32) != 64'd0) begin
						res.value = q16mds_pkg::MIN_WORD;
						res.status = q16mds_pkg::ST_OVF;
					end else
						res.value = rv[31:0];
				end
			end
			q16mds_pkg::OP_DIV: begin
				na = {32'd0, (a[31] ? 32'd0 - a : a)};
				nb = {32'd0, (b[31] ? 32'd0 - b : b)};
				if (b == 32'd0) begin
					res.value = q16mds_pkg::MIN_WORD;
					res.status = q16mds_pkg::ST_DIVZ;
				end else begin
					q = (na << 17) / nb;
					if (round_on)
						q = q + 64'd1;
					if (q > 64'hFFFF_FFFF) begin
						res.value = q16mds_pkg::MIN_WORD;
						res.status = q16mds_pkg::ST_OVF;
					end else begin
						mag = q >> 1;
						if (a[31] ^ b[31])
							mag = 64'd0 - mag;
						res.value = mag[31:0];
					end
				end
			end
			q16mds_pkg::OP_SQRT: begin
				n = {32'd0, (a[31] ? 32'd0 - a : a)} << 16;
				rem = n;
				root = 64'd0;
				bitv = 64'd1 << 48;
				while (bitv > rem)
					bitv = bitv >> 2;
				while (bitv != 64'd0) begin
					if (rem >= root + bitv) begin
						rem = rem - (root + bitv);
						root = (root >> 1) + bitv;
					end else
						root = root >> 1;
					bitv = bitv >> 2;
				end
				if (round_on && rem > root)
					root = root + 64'd1;
				if (a[31])
					root = 64'd0 - root;
				res.value = root[31:0];
			end
			default: ;
		endcase
		return res;
	endfunction

	task automatic send_op(logic [1:0] kind, logic [31:0] a, logic [31:0] b);
		int gap;
		if (idle_enable && $urandom_range(0, 5) == 0) begin
			gap = $urandom_range(1, 16);
			req.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req.valid <= 1'b1;
		req.kind <= kind;
		req.operand_a <= a;
		req.operand_b <= b;
		@(posedge clk);
		while (!req.ready)
			@(posedge clk);
		expected_results.push_back(q16_compute(kind, a, b));
		sent_count++;
	endtask

	task automatic stop_sending();
		req.valid <= 1'b0;
	endtask

	task automatic wait_drained();
		stop_sending();
		@(posedge clk);
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic write_rounding(logic mode);
		wait_drained();
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= mode;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		round_on = mode;
		@(posedge clk);
	endtask

	function automatic logic [31:0] pick_operand();
		case ($urandom_range(0, 7))
			0: return 32'h8000_0000;
			1: return 32'h7FFF_FFFF;
			2: return $urandom_range(0, 3) == 0 ? 32'd0 : 32'hFFFF_FFFF;
			3: return {{16{$urandom_range(0, 1) == 1}}, 16'($urandom)};
			4: return 32'($urandom_range(0, 255)) << 16;
			5: return 32'd0 - (32'($urandom_range(0, 255)) << 16);
			default: return $urandom;
		endcase
	endfunction

	task automatic test_directed();
		logic [31:0] edge_vals[8] = '{32'h0, 32'h1, 32'hFFFF_FFFF, 32'h7FFF_FFFF,
			32'h8000_0000, 32'h0001_0000, 32'hFFFF_0000, 32'h0000_8000};
		for (int i = 0; i < 8; i++) begin
			send_op(q16mds_pkg::OP_MUL, edge_vals[i], edge_vals[(i + 3) % 8]);
			send_op(q16mds_pkg::OP_DIV, edge_vals[i], edge_vals[(i + 5) % 8]);
		end
		send_op(q16mds_pkg::OP_SQRT, 32'h7FFF_FFFF, 32'h0);
		send_op(q16mds_pkg::OP_SQRT, 32'h8000_0000, 32'hFFFF_FFFF);
		send_op(q16mds_pkg::OP_SQRT, 32'h0000_0002, 32'h0);
		send_op(q16mds_pkg::OP_DIV, 32'h0000_0001, 32'h0000_0000);
		send_op(q16mds_pkg::OP_MUL, 32'hFFFF_FFFF, 32'h0000_8000);
		send_op(q16mds_pkg::OP_MUL, 32'h7FFF_FFFF, 32'h0001_0000);
		send_op(q16mds_pkg::OP_DIV, 32'h7FFF_FFFF, 32'h0000_FFFF);
		send_op(2'd3, 32'h1234_5678, 32'h9ABC_DEF0);
	endtask

	task automatic test_random(int count);
		logic [1:0] kind;
		for (int i = 0; i < count; i++) begin
			kind = ($urandom_range(0, 40) == 0) ? 2'd3 : 2'($urandom_range(0, 2));
			send_op(kind, pick_operand(), pick_operand());
		end
	endtask

	task automatic test_backpressure();
		long_hold = 1'b1;
		test_random(80);
		long_hold = 1'b0;
		wait_drained();
	endtask

	// result receiver
	initial begin
		int hold;
		rsp.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			if (long_hold) begin
				rsp.ready <= 1'b0;
				hold = 0;
				while (long_hold && hold < 300) begin
					@(posedge clk);
					hold++;
				end
			end else if (idle_enable && $urandom_range(0, 5) == 0) begin
				rsp.ready <= 1'b0;
				repeat ($urandom_range(1, 16)) @(posedge clk);
			end
			rsp.ready <= 1'b1;
			@(posedge clk);
		end
	end

	// result checker
	always @(posedge clk) begin
		q16_result_t exp_r;
		if (arst_n && rsp.valid && rsp.ready) begin
			result_count++;
			if (expected_results.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("unexpected result transaction value=%h status=%0d",
						rsp.value, rsp.status);
			end else begin
				exp_r = expected_results.pop_front();
				if (rsp.value !== exp_r.value || rsp.status !== exp_r.status) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("mismatch: expected value=%h status=%0d, got value=%h status=%0d",
							exp_r.value, exp_r.status, rsp.value, rsp.status);
				end
			end
		end
	end

	initial begin
		#50ms;
		$display("Simulation FAILED");
		$finish;
	end

	initial begin
		req.valid <= 1'b0;
		req.kind <= q16mds_pkg::OP_MUL;
		req.operand_a <= 32'd0;
		req.operand_b <= 32'd0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		write_rounding(1'b0);
		test_directed();
		test_random(400);
		write_rounding(1'b1);
		test_random(400);
		test_backpressure();
		write_rounding(1'b0);
		test_random(400);
		write_rounding(1'b1);
		idle_enable = 1'b0;
		test_random(420);
		wait_drained();
		$display("covered %0d transactions sent, %0d results checked", sent_count,
			result_count);
		$display("multiply, divide, square root, unused kind, rounding on and off");
		if (mismatch_count == 0 && expected_results.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

FILE: q16_mul_div_sqrt_unit_top.f
sv/q16mds_pkg.sv
sv/q16mds_if.sv
sv/q16mds_step.sv
sv/q16mds_final.sv
sv/q16_mul_div_sqrt_unit_top.sv
tb/tb_q16_mul_div_sqrt_unit_top.sv
